FILE: rtl/row_lock_manager_unit_assert.svh
// assertion macros shared by the row lock manager
`ifndef ROW_LOCK_MANAGER_UNIT_ASSERT_SVH
`define ROW_LOCK_MANAGER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RLM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define RLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/rlm_pkg.sv
// ----------------------------------------------------------------------------
// rlm_pkg
// types, codes and helpers shared by the row lock manager modules
// ----------------------------------------------------------------------------
package rlm_pkg;

  localparam int unsigned TsW = 64;
  localparam int unsigned IdW = 32;

  typedef enum logic [2:0] {
    ST_GRANT    = 3'd0,
    ST_WAIT     = 3'd1,
    ST_ABORT    = 3'd2,
    ST_RELEASED = 3'd3,
    ST_ERROR    = 3'd4
  } rlm_status_e;

  typedef enum logic [1:0] {
    POL_NO_WAIT   = 2'd0,
    POL_WAIT_DIE  = 2'd1,
    POL_DEADLOCK  = 2'd2,
    POL_CALVIN    = 2'd3
  } rlm_policy_e;

  typedef enum logic [1:0] {
    HM_NONE      = 2'd0,
    HM_SHARED    = 2'd1,
    HM_EXCLUSIVE = 2'd2
  } rlm_hmode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACQ_HEAD,
    S_ACQ_OWN,
    S_ACQ_POS,
    S_REL_OWN,
    S_REL_WAIT,
    S_PCHK,
    S_OUT
  } rlm_state_e;

  localparam logic [2:0] RegPolicy = 3'd0;

  typedef struct packed {
    logic lt;
    logic gt;
    logic eq;
  } rlm_cmp_t;

  function automatic logic modes_conflict(input logic [1:0] held, input logic [1:0] want);
    logic res;
    res = 1'b0;
    if ((held != HM_NONE) && (want != HM_NONE)) begin
      res = (held == HM_EXCLUSIVE) || (want == HM_EXCLUSIVE);
    end
    return res;
  endfunction

  // request mode bit (0 shared, 1 exclusive) to held-mode code
  function automatic logic [1:0] to_hmode(input logic mode_bit);
    return mode_bit ? HM_EXCLUSIVE : HM_SHARED;
  endfunction

endpackage

FILE: rtl/rlm_cmp.sv
// ----------------------------------------------------------------------------
// rlm_cmp
// shared 64-bit magnitude and equality comparator used by every scan step
// ----------------------------------------------------------------------------
module rlm_cmp
  import rlm_pkg::*;
(
  input  logic [TsW-1:0] a_i,
  input  logic [TsW-1:0] b_i,
  output rlm_cmp_t       res_o
);

  assign res_o.lt = a_i < b_i;
  assign res_o.gt = a_i > b_i;
  assign res_o.eq = a_i == b_i;

endmodule

FILE: rtl/row_lock_manager_unit.sv
// ----------------------------------------------------------------------------
// row_lock_manager_unit
// two-phase locking arbiter for one row: owner set, waiter queue, held mode
// ----------------------------------------------------------------------------
// One request is handled at a time and s_axis_tready_o is high only when the
// block is idle. All timestamp and id checks go through one shared 64-bit
// comparator, one owner or waiter entry per cycle. Under wait-die an acquire
// may scan the owners (S_ACQ_OWN), then the queue (S_ACQ_POS). A release
// scans the owners (S_REL_OWN), then the waiters (S_REL_WAIT); its result
// and each promoted waiter's grant go through S_PCHK and S_OUT, each result
// held until the master side takes it. No clearing pass runs after reset.
module row_lock_manager_unit
  import rlm_pkg::*;
#(
  parameter int unsigned MAX_OWNERS  = 16,
  parameter int unsigned MAX_WAITERS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // apb configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // request stream
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [95:0]   s_axis_tdata_i,  // txn_id [31:0], txn_ts [95:32]
  input  logic [1:0]    s_axis_tuser_i,  // cmd [0], mode [1]
  // result stream
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [31:0]   m_axis_tdata_o,  // grant_txn_id [31:0]
  output logic [2:0]    m_axis_tuser_o,  // status [2:0]
  output logic          m_axis_tlast_o
);

  localparam int unsigned OIW = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
  localparam int unsigned OCW = $clog2(MAX_OWNERS + 1);
  localparam int unsigned WIW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned WCW = $clog2(MAX_WAITERS + 1);

  rlm_state_e state_q, state_d;
  logic [1:0] policy_q;

  logic [IdW-1:0] id_q, id_d;
  logic [TsW-1:0] ts_q, ts_d;
  logic [1:0]     lmode_q, lmode_d;

  logic [IdW-1:0] oid_q [MAX_OWNERS];
  logic [IdW-1:0] oid_d [MAX_OWNERS];
  logic [TsW-1:0] ost_q [MAX_OWNERS];
  logic [TsW-1:0] ost_d [MAX_OWNERS];
  logic [MAX_OWNERS-1:0] ovld_q, ovld_d;
  logic [OCW-1:0] ocnt_q, ocnt_d;

  logic [IdW-1:0] wid_q [MAX_WAITERS];
  logic [IdW-1:0] wid_d [MAX_WAITERS];
  logic [TsW-1:0] wst_q [MAX_WAITERS];
  logic [TsW-1:0] wst_d [MAX_WAITERS];
  logic           wmd_q [MAX_WAITERS];
  logic           wmd_d [MAX_WAITERS];
  logic [WCW-1:0] wcnt_q, wcnt_d;

  logic [1:0]     held_q, held_d;
  logic [OIW-1:0] oidx_q, oidx_d;
  logic [WCW-1:0] widx_q, widx_d;

  logic [2:0]     pend_st_q, pend_st_d;
  logic [IdW-1:0] pend_id_q, pend_id_d;
  logic           promo_q, promo_d;
  logic [2:0]     out_st_q, out_st_d;
  logic [IdW-1:0] out_id_q, out_id_d;
  logic           out_last_q, out_last_d;

  logic [TsW-1:0] cmp_a, cmp_b;
  rlm_cmp_t       cmp;
  logic           free_found;
  logic [OIW-1:0] free_idx;
  logic           wfull;
  logic [WIW-1:0] wsel;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == RegPolicy) ? {30'd0, policy_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_NO_WAIT;
    end else if (psel && penable && pwrite && (paddr == RegPolicy)) begin
      policy_q <= pwdata[1:0];
    end
  end

  assign wsel  = widx_q[WIW-1:0];
  assign wfull = (wcnt_q == WCW'(MAX_WAITERS));

  // lowest free owner slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_OWNERS - 1; i >= 0; i--) begin
      if (!ovld_q[i]) begin
        free_found = 1'b1;
        free_idx   = OIW'(i);
      end
    end
  end

  // operand select for the shared comparator
  always_comb begin
    cmp_a = ts_q;
    cmp_b = wst_q[0];
    unique case (state_q)
      S_ACQ_OWN:  cmp_b = ost_q[oidx_q];
      S_ACQ_POS:  cmp_b = wst_q[wsel];
      S_REL_OWN: begin
        cmp_a = {{(TsW-IdW){1'b0}}, id_q};
        cmp_b = {{(TsW-IdW){1'b0}}, oid_q[oidx_q]};
      end
      S_REL_WAIT: begin
        cmp_a = {{(TsW-IdW){1'b0}}, id_q};
        cmp_b = {{(TsW-IdW){1'b0}}, wid_q[wsel]};
      end
      default: cmp_b = wst_q[0];
    endcase
  end

  rlm_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp)
  );

  always_comb begin
    logic conf;
    logic cond;
    logic [WCW-1:0] ins_p;
    logic do_ins;
    logic [WCW-1:0] rem_p;
    logic do_rem;
    logic do_add;
    logic [IdW-1:0] add_id;
    logic [TsW-1:0] add_ts;
    logic [1:0]     add_md;
    logic emit;
    logic [2:0] emit_st;

    state_d    = state_q;
    id_d       = id_q;
    ts_d       = ts_q;
    lmode_d    = lmode_q;
    oid_d      = oid_q;
    ost_d      = ost_q;
    ovld_d     = ovld_q;
    ocnt_d     = ocnt_q;
    wid_d      = wid_q;
    wst_d      = wst_q;
    wmd_d      = wmd_q;
    wcnt_d     = wcnt_q;
    held_d     = held_q;
    oidx_d     = oidx_q;
    widx_d     = widx_q;
    pend_st_d  = pend_st_q;
    pend_id_d  = pend_id_q;
    promo_d    = promo_q;
    out_st_d   = out_st_q;
    out_id_d   = out_id_q;
    out_last_d = out_last_q;
    conf    = 1'b0;
    cond    = 1'b0;
    ins_p   = wcnt_q;
    do_ins  = 1'b0;
    rem_p   = '0;
    do_rem  = 1'b0;
    do_add  = 1'b0;
    add_id  = id_q;
    add_ts  = ts_q;
    add_md  = lmode_q;
    emit    = 1'b0;
    emit_st = ST_ERROR;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          id_d    = s_axis_tdata_i[31:0];
          ts_d    = s_axis_tdata_i[95:32];
          lmode_d = to_hmode(s_axis_tuser_i[1]);
          oidx_d  = '0;
          widx_d  = '0;
          state_d = s_axis_tuser_i[0] ? S_REL_OWN : S_ACQ_HEAD;
        end
      end
      S_ACQ_HEAD: begin
        conf = modes_conflict(held_q, lmode_q);
        if ((policy_q == POL_WAIT_DIE) && (wcnt_q != '0) && cmp.lt) conf = 1'b1;
        if (((policy_q == POL_DEADLOCK) || (policy_q == POL_CALVIN)) && (wcnt_q != '0)) begin
          conf = 1'b1;
        end
        if (!conf) begin
          emit = 1'b1;
          if (free_found) begin
            do_add  = 1'b1;
            emit_st = ST_GRANT;
          end else begin
            emit_st = ST_ERROR;
          end
        end else begin
          case (policy_q)
            POL_NO_WAIT: begin
              emit    = 1'b1;
              emit_st = ST_ABORT;
            end
            POL_WAIT_DIE: state_d = S_ACQ_OWN;
            default: begin
              emit = 1'b1;
              if (wfull) begin
                emit_st = ST_ERROR;
              end else begin
                do_ins  = 1'b1;
                ins_p   = wcnt_q;
                emit_st = ST_WAIT;
              end
            end
          endcase
        end
      end
      S_ACQ_OWN: begin
        if (ovld_q[oidx_q] && cmp.gt) begin
          emit    = 1'b1;
          emit_st = ST_ABORT;
        end else if (oidx_q == OIW'(MAX_OWNERS - 1)) begin
          if (wfull) begin
            emit    = 1'b1;
            emit_st = ST_ERROR;
          end else begin
            widx_d  = '0;
            state_d = S_ACQ_POS;
          end
        end else begin
          oidx_d = oidx_q + OIW'(1);
        end
      end
      S_ACQ_POS: begin
        if ((widx_q < wcnt_q) && cmp.lt) begin
          widx_d = widx_q + WCW'(1);
        end else begin
          do_ins  = 1'b1;
          ins_p   = widx_q;
          emit    = 1'b1;
          emit_st = ST_WAIT;
        end
      end
      S_REL_OWN: begin
        if (ovld_q[oidx_q] && cmp.eq) begin
          ovld_d[oidx_q] = 1'b0;
          ocnt_d = ocnt_q - OCW'(1);
          if (ocnt_q == OCW'(1)) held_d = HM_NONE;
          pend_st_d = ST_RELEASED;
          pend_id_d = id_q;
          state_d   = S_PCHK;
        end else if (oidx_q == OIW'(MAX_OWNERS - 1)) begin
          widx_d  = '0;
          state_d = S_REL_WAIT;
        end else begin
          oidx_d = oidx_q + OIW'(1);
        end
      end
      S_REL_WAIT: begin
        pend_id_d = id_q;
        if (widx_q >= wcnt_q) begin
          pend_st_d = ST_ERROR;
          state_d   = S_PCHK;
        end else if (cmp.eq) begin
          do_rem    = 1'b1;
          rem_p     = widx_q;
          pend_st_d = ST_RELEASED;
          state_d   = S_PCHK;
        end else begin
          widx_d = widx_q + WCW'(1);
        end
      end
      S_PCHK: begin
        // promote the queue head while it is compatible and a slot is free
        cond = (wcnt_q != '0) && !modes_conflict(held_q, to_hmode(wmd_q[0])) && free_found;
        out_st_d   = pend_st_q;
        out_id_d   = pend_id_q;
        out_last_d = !cond;
        promo_d    = cond;
        state_d    = S_OUT;
        if (cond) begin
          do_add    = 1'b1;
          add_id    = wid_q[0];
          add_ts    = wst_q[0];
          add_md    = to_hmode(wmd_q[0]);
          do_rem    = 1'b1;
          rem_p     = '0;
          pend_st_d = ST_GRANT;
          pend_id_d = wid_q[0];
        end
      end
      S_OUT: begin
        if (m_axis_tready_i) begin
          state_d = promo_q ? S_PCHK : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (emit) begin
      out_st_d   = emit_st;
      out_id_d   = id_q;
      out_last_d = 1'b1;
      promo_d    = 1'b0;
      state_d    = S_OUT;
    end

    if (do_add) begin
      oid_d[free_idx]  = add_id;
      ost_d[free_idx]  = add_ts;
      ovld_d[free_idx] = 1'b1;
      ocnt_d = ocnt_q + OCW'(1);
      held_d = add_md;
    end

    // queue insert and remove as whole-queue shifts by one place
    if (do_ins) begin
      for (int i = 1; i < MAX_WAITERS; i++) begin
        if (WCW'(i) > ins_p) begin
          wid_d[i] = wid_q[i-1];
          wst_d[i] = wst_q[i-1];
          wmd_d[i] = wmd_q[i-1];
        end
      end
      wid_d[ins_p[WIW-1:0]] = id_q;
      wst_d[ins_p[WIW-1:0]] = ts_q;
      wmd_d[ins_p[WIW-1:0]] = (lmode_q == HM_EXCLUSIVE);
      wcnt_d = wcnt_q + WCW'(1);
    end
    if (do_rem) begin
      for (int i = 0; i < MAX_WAITERS - 1; i++) begin
        if (WCW'(i) >= rem_p) begin
          wid_d[i] = wid_q[i+1];
          wst_d[i] = wst_q[i+1];
          wmd_d[i] = wmd_q[i+1];
        end
      end
      wcnt_d = wcnt_q - WCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= '0;
      ocnt_q  <= '0;
      wcnt_q  <= '0;
      held_q  <= HM_NONE;
      promo_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      ocnt_q  <= ocnt_d;
      wcnt_q  <= wcnt_d;
      held_q  <= held_d;
      promo_q <= promo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    ts_q       <= ts_d;
    lmode_q    <= lmode_d;
    oid_q      <= oid_d;
    ost_q      <= ost_d;
    wid_q      <= wid_d;
    wst_q      <= wst_d;
    wmd_q      <= wmd_d;
    oidx_q     <= oidx_d;
    widx_q     <= widx_d;
    pend_st_q  <= pend_st_d;
    pend_id_q  <= pend_id_d;
    out_st_q   <= out_st_d;
    out_id_q   <= out_id_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tdata_o  = out_id_q;
  assign m_axis_tuser_o  = out_st_q;
  assign m_axis_tlast_o  = out_last_q;

`include "row_lock_manager_unit_assert.svh"

  `RLM_ASSERT_IMPL(a_idle_no_result, clk_i, rst_ni, s_axis_tready_o, !m_axis_tvalid_o)
  `RLM_ASSERT_IMPL(a_owner_bound, clk_i, rst_ni, 1'b1, ocnt_q <= OCW'(MAX_OWNERS))
  `RLM_ASSERT_IMPL(a_waiter_bound, clk_i, rst_ni, 1'b1, wcnt_q <= WCW'(MAX_WAITERS))
  `RLM_ASSERT_IMPL(a_held_none, clk_i, rst_ni, 1'b1, (ocnt_q == '0) == (held_q == HM_NONE))
  `RLM_ASSERT_NEXT(a_last_to_idle, clk_i, rst_ni,
                   m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, s_axis_tready_o)

endmodule
